### rtl/rafu_pkg.sv
// Shared types, widths and constants for the rotational anisotropy field unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rafu_pkg;

  // Port widths
  localparam int unsigned VecW      = 16;   // Q2.14 vector component
  localparam int unsigned KW        = 32;   // Q16.16 constant
  localparam int unsigned ResW      = 32;   // Q16.16 result

  // Projection: three Q28 products summed, rounded to Q16
  localparam int unsigned DotW      = 34;
  localparam int unsigned ProjShift = 12;
  localparam int unsigned ProjW     = 21;

  // Polynomial terms in Q32
  localparam int unsigned SqW       = 41;
  localparam int unsigned AW        = 41;   // Sz^2 - 3/7
  localparam int unsigned BW        = 42;   // 3 Sz^2 - 3/7
  localparam int unsigned ALoW      = 20;   // low slice of A
  localparam int unsigned BLoW      = 21;   // low slice of B
  localparam int unsigned PartW     = 62;   // recombined cubic products
  localparam int unsigned CubeShift = 32;
  localparam int unsigned UW        = 28;   // rnd(Sz*A, 32)
  localparam int unsigned WW        = 30;   // rnd(Sy*B, 32)

  // Scaling by k
  localparam int unsigned KuW       = 60;
  localparam int unsigned KwW       = 62;
  localparam int unsigned KShift    = 16;
  localparam int unsigned YcW       = 43;
  localparam int unsigned ZcW       = 45;

  // Final products
  localparam int unsigned YLoW      = 22;   // low slice of yc
  localparam int unsigned ZLoW      = 22;   // low slice of zc
  localparam int unsigned FldSumW   = 60;
  localparam int unsigned FldShift  = 14;
  localparam int unsigned FldW      = 46;
  localparam int unsigned EyW       = 63;
  localparam int unsigned EngShift  = 16;
  localparam int unsigned EngW      = 48;

  // Register stages from input to output register
  localparam int unsigned NumStages = 12;

  // 3/7 in Q32
  localparam logic signed [31:0] ThreeSevenths = 32'sd1840700270;

  localparam logic signed [ResW-1:0] ResMax = {1'b0, {(ResW-1){1'b1}}};
  localparam logic signed [ResW-1:0] ResMin = {1'b1, {(ResW-1){1'b0}}};

  typedef struct {
    logic signed [VecW-1:0] e [3];
    logic signed [VecW-1:0] g [3];
  } axes_t;

  typedef struct {
    logic signed [VecW-1:0] spin [3];
    axes_t                  axes;
    logic signed [KW-1:0]   k;
    logic                   last;
  } item_t;

  typedef struct {
    logic signed [ProjW-1:0] sz;
    logic signed [ProjW-1:0] sy;
    axes_t                   axes;
    logic signed [KW-1:0]    k;
    logic                    last;
  } proj_t;

  typedef struct {
    logic signed [YcW-1:0]   yc;
    logic signed [ZcW-1:0]   zc;
    logic signed [ProjW-1:0] sy;
    axes_t                   axes;
    logic                    last;
  } coef_t;

  typedef struct {
    logic signed [FldW-1:0] fld [3];
    logic signed [EngW-1:0] eng;
    logic                   last;
  } rnd_t;

  // Clamp to the signed 32-bit result range
  function automatic logic signed [ResW-1:0] sat_res(input logic signed [EngW-1:0] x);
    logic signed [ResW-1:0] r;
    if (x > EngW'(ResMax)) begin
      r = ResMax;
    end else if (x < EngW'(ResMin)) begin
      r = ResMin;
    end else begin
      r = x[ResW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/rafu_if.sv
// Valid/ready channel interfaces: input item, result item, configuration write.
// Depends on rafu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rafu_in_if;
  import rafu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [VecW-1:0] spin_x;
  logic signed [VecW-1:0] spin_y;
  logic signed [VecW-1:0] spin_z;
  logic signed [VecW-1:0] easy_axis_x;
  logic signed [VecW-1:0] easy_axis_y;
  logic signed [VecW-1:0] easy_axis_z;
  logic signed [VecW-1:0] side_axis_x;
  logic signed [VecW-1:0] side_axis_y;
  logic signed [VecW-1:0] side_axis_z;
  logic signed [KW-1:0]   aniso_const;
  logic                   last_atom;

  modport source (
    output valid, spin_x, spin_y, spin_z, easy_axis_x, easy_axis_y, easy_axis_z,
           side_axis_x, side_axis_y, side_axis_z, aniso_const, last_atom,
    input  ready
  );
  modport sink (
    input  valid, spin_x, spin_y, spin_z, easy_axis_x, easy_axis_y, easy_axis_z,
           side_axis_x, side_axis_y, side_axis_z, aniso_const, last_atom,
    output ready
  );
endinterface

interface rafu_out_if;
  import rafu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [ResW-1:0] field_x_add;
  logic signed [ResW-1:0] field_y_add;
  logic signed [ResW-1:0] field_z_add;
  logic signed [ResW-1:0] energy;
  logic                   last_atom_out;

  modport source (
    output valid, field_x_add, field_y_add, field_z_add, energy, last_atom_out,
    input  ready
  );
  modport sink (
    input  valid, field_x_add, field_y_add, field_z_add, energy, last_atom_out,
    output ready
  );
endinterface

interface rafu_cfg_if;
  logic valid;
  logic ready;
  logic wdata;

  modport source (output valid, wdata, input ready);
  modport sink (input valid, wdata, output ready);
endinterface

`default_nettype wire

### rtl/rafu_proj.sv
// Projection stages: spin onto easy and side axes, rounded to Q16.
// Depends on rafu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rafu_proj (
  input  logic            clk_i,
  input  logic [1:0]      en_i,
  input  rafu_pkg::item_t item_i,
  output rafu_pkg::proj_t proj_o
);
  import rafu_pkg::*;

  logic signed [2*VecW-1:0] pse_q [3];
  logic signed [2*VecW-1:0] psg_q [3];
  axes_t                    axes_q;
  logic signed [KW-1:0]     k_q;
  logic                     last_q;
  logic signed [DotW-1:0]   sz_sum;
  logic signed [DotW-1:0]   sy_sum;
  proj_t                    proj_d;
  proj_t                    proj_q;

  // Component products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        pse_q[i] <= item_i.spin[i] * item_i.axes.e[i];
        psg_q[i] <= item_i.spin[i] * item_i.axes.g[i];
      end
      axes_q <= item_i.axes;
      k_q    <= item_i.k;
      last_q <= item_i.last;
    end
  end

  // Sum and round half up to Q16
  always_comb begin
    sz_sum = DotW'(pse_q[0]) + DotW'(pse_q[1]) + DotW'(pse_q[2])
           + (DotW'(1) <<< (ProjShift - 1));
    sy_sum = DotW'(psg_q[0]) + DotW'(psg_q[1]) + DotW'(psg_q[2])
           + (DotW'(1) <<< (ProjShift - 1));
    proj_d.sz   = sz_sum[ProjW+ProjShift-1:ProjShift];
    proj_d.sy   = sy_sum[ProjW+ProjShift-1:ProjShift];
    proj_d.axes = axes_q;
    proj_d.k    = k_q;
    proj_d.last = last_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      proj_q <= proj_d;
    end
  end

  assign proj_o = proj_q;

endmodule

`default_nettype wire

### rtl/rafu_poly.sv
// Polynomial stages: Sz^2, the two 3/7 terms, cubic products and scaling by k.
// Depends on rafu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rafu_poly (
  input  logic            clk_i,
  input  logic [5:0]      en_i,
  input  rafu_pkg::proj_t proj_i,
  output rafu_pkg::coef_t coef_o
);
  import rafu_pkg::*;

  localparam int unsigned PalW = ProjW + ALoW + 1;
  localparam int unsigned PahW = ProjW + AW - ALoW;
  localparam int unsigned PblW = ProjW + BLoW + 1;
  localparam int unsigned PbhW = ProjW + BW - BLoW;

  logic signed [2*ProjW-1:0] sq_full;
  logic signed [SqW-1:0]     sq_q;
  proj_t                     p3_q;
  logic signed [AW-1:0]      a_q;
  logic signed [BW-1:0]      b_q;
  proj_t                     p4_q;
  logic signed [PalW-1:0]    pal_q;
  logic signed [PahW-1:0]    pah_q;
  logic signed [PblW-1:0]    pbl_q;
  logic signed [PbhW-1:0]    pbh_q;
  proj_t                     p5_q;
  logic signed [PartW-1:0]   sum_a;
  logic signed [PartW-1:0]   sum_b;
  logic signed [UW-1:0]      u_q;
  logic signed [WW-1:0]      w_q;
  proj_t                     p6_q;
  logic signed [KuW-1:0]     ku_q;
  logic signed [KwW-1:0]     kw_q;
  proj_t                     p7_q;
  logic signed [KuW-1:0]     ku_sum;
  logic signed [KwW-1:0]     kw_sum;
  coef_t                     coef_d;
  coef_t                     coef_q;

  assign sq_full = proj_i.sz * proj_i.sz;

  always_ff @(posedge clk_i) begin
    // Square the easy-axis projection
    if (en_i[0]) begin
      sq_q <= sq_full[SqW-1:0];
      p3_q <= proj_i;
    end
    // Subtract 3/7
    if (en_i[1]) begin
      a_q  <= AW'(sq_q) - AW'(ThreeSevenths);
      b_q  <= BW'(sq_q) + BW'(sq_q) + BW'(sq_q) - BW'(ThreeSevenths);
      p4_q <= p3_q;
    end
    // Partial products on the low and high slices of A and B
    if (en_i[2]) begin
      pal_q <= p4_q.sz * $signed({1'b0, a_q[ALoW-1:0]});
      pah_q <= p4_q.sz * $signed(a_q[AW-1:ALoW]);
      pbl_q <= p4_q.sy * $signed({1'b0, b_q[BLoW-1:0]});
      pbh_q <= p4_q.sy * $signed(b_q[BW-1:BLoW]);
      p5_q  <= p4_q;
    end
  end

  // Recombine slices, round half up from Q48 to Q16
  always_comb begin
    sum_a = (PartW'(pah_q) <<< ALoW) + PartW'(pal_q) + (PartW'(1) <<< (CubeShift - 1));
    sum_b = (PartW'(pbh_q) <<< BLoW) + PartW'(pbl_q) + (PartW'(1) <<< (CubeShift - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      u_q  <= sum_a[UW+CubeShift-1:CubeShift];
      w_q  <= sum_b[WW+CubeShift-1:CubeShift];
      p6_q <= p5_q;
    end
    // Scale by k
    if (en_i[4]) begin
      ku_q <= p6_q.k * u_q;
      kw_q <= p6_q.k * w_q;
      p7_q <= p6_q;
    end
  end

  // Round half up to Q16
  always_comb begin
    ku_sum      = ku_q + (KuW'(1) <<< (KShift - 1));
    kw_sum      = kw_q + (KwW'(1) <<< (KShift - 1));
    coef_d.yc   = ku_sum[YcW+KShift-1:KShift];
    coef_d.zc   = kw_sum[ZcW+KShift-1:KShift];
    coef_d.sy   = p7_q.sy;
    coef_d.axes = p7_q.axes;
    coef_d.last = p7_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

### rtl/rafu_out.sv
// Output stages: field vector and energy products, recombined and rounded.
// Depends on rafu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rafu_out (
  input  logic            clk_i,
  input  logic [2:0]      en_i,
  input  rafu_pkg::coef_t coef_i,
  output rafu_pkg::rnd_t  rnd_o
);
  import rafu_pkg::*;

  localparam int unsigned GylW = VecW + YLoW + 1;
  localparam int unsigned GyhW = VecW + YcW - YLoW;
  localparam int unsigned EzlW = VecW + ZLoW + 1;
  localparam int unsigned EzhW = VecW + ZcW - ZLoW;
  localparam int unsigned EylW = ProjW + YLoW + 1;
  localparam int unsigned EyhW = ProjW + YcW - YLoW;

  logic signed [GylW-1:0]    gyl_q [3];
  logic signed [GyhW-1:0]    gyh_q [3];
  logic signed [EzlW-1:0]    ezl_q [3];
  logic signed [EzhW-1:0]    ezh_q [3];
  logic signed [EylW-1:0]    eyl_q;
  logic signed [EyhW-1:0]    eyh_q;
  logic                      last9_q;
  logic signed [FldSumW-1:0] yg_q [3];
  logic signed [FldSumW-1:0] ze_q [3];
  logic signed [EyW-1:0]     ey_q;
  logic                      last10_q;
  logic signed [FldSumW-1:0] fsum [3];
  logic signed [EyW-1:0]     esum;
  rnd_t                      rnd_d;
  rnd_t                      rnd_q;

  always_ff @(posedge clk_i) begin
    // Partial products on the low and high slices of yc and zc
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        gyl_q[i] <= coef_i.axes.g[i] * $signed({1'b0, coef_i.yc[YLoW-1:0]});
        gyh_q[i] <= coef_i.axes.g[i] * $signed(coef_i.yc[YcW-1:YLoW]);
        ezl_q[i] <= coef_i.axes.e[i] * $signed({1'b0, coef_i.zc[ZLoW-1:0]});
        ezh_q[i] <= coef_i.axes.e[i] * $signed(coef_i.zc[ZcW-1:ZLoW]);
      end
      eyl_q   <= coef_i.sy * $signed({1'b0, coef_i.yc[YLoW-1:0]});
      eyh_q   <= coef_i.sy * $signed(coef_i.yc[YcW-1:YLoW]);
      last9_q <= coef_i.last;
    end
    // Recombine slices
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) begin
        yg_q[i] <= (FldSumW'(gyh_q[i]) <<< YLoW) + FldSumW'(gyl_q[i]);
        ze_q[i] <= (FldSumW'(ezh_q[i]) <<< ZLoW) + FldSumW'(ezl_q[i]);
      end
      ey_q     <= (EyW'(eyh_q) <<< YLoW) + EyW'(eyl_q);
      last10_q <= last9_q;
    end
  end

  // Round half up; negate the energy
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fsum[i]      = yg_q[i] + ze_q[i] + (FldSumW'(1) <<< (FldShift - 1));
      rnd_d.fld[i] = fsum[i][FldW+FldShift-1:FldShift];
    end
    esum       = ey_q + (EyW'(1) <<< (EngShift - 1));
    rnd_d.eng  = -EngW'($signed(esum[EyW-1:EngShift]));
    rnd_d.last = last10_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      rnd_q <= rnd_d;
    end
  end

  assign rnd_o = rnd_q;

endmodule

`default_nettype wire

### rtl/rotational_anisotropy_field_4_1_unit.sv
// Top level of the rotational anisotropy field unit; depends on rafu_pkg, rafu_if,
// rafu_proj, rafu_poly and rafu_out.
`timescale 1ns / 1ps
`default_nettype none

// Per atom, projects the spin onto the material's easy axis e and side axis g
// (Sz, Sy), then returns the field increment k*Sz*(Sz^2-3/7)*g + k*Sy*(3Sz^2-3/7)*e
// and the energy -k*Sy*Sz*(Sz^2-3/7), all saturated to signed Q16.16. The field
// increment reads zero while the enable register is clear; the energy is always
// given. The unit is a 12-stage pipeline (two projection stages, six polynomial
// stages, three output-product stages and the output register) and takes one item
// every cycle unless an output stall has backed up to the input; each result passes
// these stages in order and waits in the output register until it is taken. Every
// stage carries its own valid bit and advances whenever it is empty or the stage
// after it advances, so bubbles close up and new items keep entering while a
// finished result waits at the output. Write the enable register only while no
// item is in flight; the write port is always ready.

module rotational_anisotropy_field_4_1_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rafu_in_if.sink    in_if,
  rafu_out_if.source out_if,
  rafu_cfg_if.sink   cfg_if
);
  import rafu_pkg::*;

  logic [NumStages-1:0]   en;
  logic [NumStages-1:0]   v_q;
  logic                   enable_q;
  item_t                  item;
  proj_t                  proj;
  coef_t                  coef;
  rnd_t                   rnd;
  logic signed [ResW-1:0] fld_q [3];
  logic signed [ResW-1:0] eng_q;
  logic                   last_q;

  // Stage advance: a stage moves when it is empty or its successor moves
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_if.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_if.ready = en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_if.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Enable register: always ready to take a write
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_if.valid) begin
      enable_q <= cfg_if.wdata;
    end
  end

  // Gather the input item
  always_comb begin
    item.spin[0]   = in_if.spin_x;
    item.spin[1]   = in_if.spin_y;
    item.spin[2]   = in_if.spin_z;
    item.axes.e[0] = in_if.easy_axis_x;
    item.axes.e[1] = in_if.easy_axis_y;
    item.axes.e[2] = in_if.easy_axis_z;
    item.axes.g[0] = in_if.side_axis_x;
    item.axes.g[1] = in_if.side_axis_y;
    item.axes.g[2] = in_if.side_axis_z;
    item.k         = in_if.aniso_const;
    item.last      = in_if.last_atom;
  end

  rafu_proj u_proj (
    .clk_i  (clk_i),
    .en_i   (en[1:0]),
    .item_i (item),
    .proj_o (proj)
  );

  rafu_poly u_poly (
    .clk_i  (clk_i),
    .en_i   (en[7:2]),
    .proj_i (proj),
    .coef_o (coef)
  );

  rafu_out u_out (
    .clk_i  (clk_i),
    .en_i   (en[10:8]),
    .coef_i (coef),
    .rnd_o  (rnd)
  );

  // Output register: saturate, drop the field while disabled, hold under stall
  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      for (int i = 0; i < 3; i++) begin
        fld_q[i] <= enable_q ? sat_res(EngW'(rnd.fld[i])) : '0;
      end
      eng_q  <= sat_res(rnd.eng);
      last_q <= rnd.last;
    end
  end

  assign out_if.valid         = v_q[NumStages-1];
  assign out_if.field_x_add   = fld_q[0];
  assign out_if.field_y_add   = fld_q[1];
  assign out_if.field_z_add   = fld_q[2];
  assign out_if.energy        = eng_q;
  assign out_if.last_atom_out = last_q;

endmodule

`default_nettype wire

### dv/rotational_anisotropy_field_4_1_unit_tb.sv
// Testbench for rotational_anisotropy_field_4_1_unit: corner and random atoms are streamed
// with random gaps and output stalls, and every result is checked against an in-bench model.
// Depends on rafu_pkg, the rafu_if channel interfaces and the unit's RTL.
`timescale 1ns / 1ps

module rotational_anisotropy_field_4_1_unit_tb;
  import rafu_pkg::*;

  // Worst case per atom is a long input gap, a long output stall and the pipeline
  // depth, for roughly 1100 atoms, plus drains around each enable write.
  // Allow several times that.
  localparam int CycleLimit = 500000;

  // One expected result item
  typedef struct packed {
    logic signed [ResW-1:0] fld_x;
    logic signed [ResW-1:0] fld_y;
    logic signed [ResW-1:0] fld_z;
    logic signed [ResW-1:0] energy;
    logic                   last;
  } atom_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rafu_in_if  in_ch ();
  rafu_out_if out_ch ();
  rafu_cfg_if cfg_ch ();

  rotational_anisotropy_field_4_1_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #10 clk = ~clk;

  // Model state: the enable register as the unit should hold it
  logic         enable_shadow = 1'b0;
  atom_result_t pending_results [$];
  atom_result_t oldest;

  int gap_pct      = 0;   // chance in percent that the sender idles before an atom
  int stall_pct    = 0;   // chance in percent that the receiver drops ready
  int stall_left   = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int atoms_sent   = 0;
  int corner_atoms = 0;
  int cfg_writes   = 0;
  int cycle_count  = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point model of one atom
  // ---------------------------------------------------------------------------

  // Round half up, then drop n fraction bits
  function automatic longint round_shift(input longint x, input int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // Clamp to the signed Q16.16 result range
  function automatic logic signed [ResW-1:0] clamp_q16(input longint x);
    if (x > longint'(ResMax)) return ResMax;
    if (x < longint'(ResMin)) return ResMin;
    return x[ResW-1:0];
  endfunction

  // Project the spin onto e and g, form the two cubic terms, scale by k and
  // build the field increment along g and e plus the energy.
  function automatic atom_result_t compute_increment(input item_t a, input logic en);
    longint s [3];
    longint e [3];
    longint g [3];
    longint fld [3];
    longint k, sz_dot, sy_dot, sz, sy, sq, a_term, b_term, yc, zc;
    atom_result_t r;
    int i;
    for (i = 0; i < 3; i++) begin
      s[i] = longint'(a.spin[i]);
      e[i] = longint'(a.axes.e[i]);
      g[i] = longint'(a.axes.g[i]);
    end
    k = longint'(a.k);
    sz_dot = s[0] * e[0] + s[1] * e[1] + s[2] * e[2];
    sy_dot = s[0] * g[0] + s[1] * g[1] + s[2] * g[2];
    sz = round_shift(sz_dot, ProjShift);
    sy = round_shift(sy_dot, ProjShift);
    sq = sz * sz;
    a_term = sq - longint'(ThreeSevenths);
    b_term = 3 * sq - longint'(ThreeSevenths);
    yc = round_shift(k * round_shift(sz * a_term, CubeShift), KShift);
    zc = round_shift(k * round_shift(sy * b_term, CubeShift), KShift);
    for (i = 0; i < 3; i++) begin
      fld[i] = en ? longint'(clamp_q16(round_shift(yc * g[i] + zc * e[i], FldShift))) : 0;
    end
    r.fld_x  = fld[0][ResW-1:0];
    r.fld_y  = fld[1][ResW-1:0];
    r.fld_z  = fld[2][ResW-1:0];
    r.energy = clamp_q16(-round_shift(yc * sy, EngShift));
    r.last   = a.last;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Atom construction
  // ---------------------------------------------------------------------------

  function automatic item_t atom(
    input logic signed [VecW-1:0] sx, sy, sz, ex, ey, ez, gx, gy, gz,
    input logic signed [KW-1:0] k, input logic last
  );
    item_t a;
    a.spin[0] = sx;   a.spin[1] = sy;   a.spin[2] = sz;
    a.axes.e[0] = ex; a.axes.e[1] = ey; a.axes.e[2] = ez;
    a.axes.g[0] = gx; a.axes.g[1] = gy; a.axes.g[2] = gz;
    a.k = k;
    a.last = last;
    return a;
  endfunction

  function automatic real rand_signed_real();
    return real'($urandom_range(2000000)) / 1000000.0 - 1.0;
  endfunction

  // Uniform direction by rejection inside the unit ball, then normalize
  function automatic void random_direction(output real v[3]);
    real n;
    do begin
      v[0] = rand_signed_real();
      v[1] = rand_signed_real();
      v[2] = rand_signed_real();
      n = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    end while (n > 1.0 || n < 0.01);
    n = $sqrt(n);
    v[0] = v[0] / n;
    v[1] = v[1] / n;
    v[2] = v[2] / n;
  endfunction

  function automatic logic signed [VecW-1:0] to_q14(input real x);
    return VecW'($rtoi(x * 16384.0 + ((x >= 0.0) ? 0.5 : -0.5)));
  endfunction

  // Mostly physical atoms (unit spin, orthonormal e and g, moderate k), the rest
  // raw bit patterns and mixes of range extremes.
  function automatic item_t random_atom();
    item_t a;
    real sd [3];
    real ed [3];
    real gd [3];
    real dot, nrm, scale;
    logic signed [VecW-1:0] v;
    int sel, i;
    sel = $urandom_range(99);
    if (sel < 60) begin
      random_direction(sd);
      random_direction(ed);
      do begin
        random_direction(gd);
        dot = gd[0] * ed[0] + gd[1] * ed[1] + gd[2] * ed[2];
        for (i = 0; i < 3; i++) gd[i] = gd[i] - dot * ed[i];
        nrm = $sqrt(gd[0] * gd[0] + gd[1] * gd[1] + gd[2] * gd[2]);
      end while (nrm < 0.05);
      // now and then a spin that is not of unit length
      scale = ($urandom_range(9) == 0) ? 0.5 + 0.7 * (rand_signed_real() + 1.0) : 1.0;
      for (i = 0; i < 3; i++) begin
        a.spin[i]   = to_q14(sd[i] * scale);
        a.axes.e[i] = to_q14(ed[i]);
        a.axes.g[i] = to_q14(gd[i] / nrm);
      end
      a.k = int'($urandom_range(2097152)) - 1048576;
    end else if (sel < 85) begin
      for (i = 0; i < 3; i++) begin
        a.spin[i]   = VecW'($urandom);
        a.axes.e[i] = VecW'($urandom);
        a.axes.g[i] = VecW'($urandom);
      end
      a.k = $urandom;
    end else begin
      for (i = 0; i < 9; i++) begin
        case ($urandom_range(5))
          0:       v = 16'sh7fff;
          1:       v = 16'sh8000;
          2:       v = '0;
          3:       v = 16'sd16384;
          4:       v = -16'sd16384;
          default: v = VecW'($urandom);
        endcase
        if (i < 3) a.spin[i] = v;
        else if (i < 6) a.axes.e[i - 3] = v;
        else a.axes.g[i - 6] = v;
      end
      case ($urandom_range(4))
        0:       a.k = 32'sh7fffffff;
        1:       a.k = 32'sh80000000;
        2:       a.k = 32'sd1;
        3:       a.k = -32'sd1;
        default: a.k = $urandom;
      endcase
    end
    a.last = ($urandom_range(7) == 0);
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Length of an idle stretch: mostly none, sometimes short, rarely long
  function automatic int pick_pause(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // Present one atom at the falling edge and hold it until it is taken
  task automatic send_atom(input item_t a);
    int gap;
    gap = pick_pause(gap_pct);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.spin_x      = a.spin[0];
    in_ch.spin_y      = a.spin[1];
    in_ch.spin_z      = a.spin[2];
    in_ch.easy_axis_x = a.axes.e[0];
    in_ch.easy_axis_y = a.axes.e[1];
    in_ch.easy_axis_z = a.axes.e[2];
    in_ch.side_axis_x = a.axes.g[0];
    in_ch.side_axis_y = a.axes.g[1];
    in_ch.side_axis_z = a.axes.g[2];
    in_ch.aniso_const = a.k;
    in_ch.last_atom   = a.last;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(compute_increment(a, enable_shadow));
    atoms_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write the enable register once the pipeline is empty
  task automatic write_enable(input logic value);
    drain_results();
    repeat (NumStages + 2) @(negedge clk);
    cfg_ch.wdata = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    enable_shadow = value;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Receiver: drop ready for random stretches, raising it again between stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      stall_left = pick_pause(stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Compare every taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, energy %0d", $time, out_ch.energy);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        results_seen++;
        if (out_ch.field_x_add !== oldest.fld_x)
          report_mismatch("field_x_add", oldest.fld_x, out_ch.field_x_add);
        if (out_ch.field_y_add !== oldest.fld_y)
          report_mismatch("field_y_add", oldest.fld_y, out_ch.field_y_add);
        if (out_ch.field_z_add !== oldest.fld_z)
          report_mismatch("field_z_add", oldest.fld_z, out_ch.field_z_add);
        if (out_ch.energy !== oldest.energy)
          report_mismatch("energy", oldest.energy, out_ch.energy);
        if (out_ch.last_atom_out !== oldest.last)
          report_mismatch("last_atom_out", oldest.last, out_ch.last_atom_out);
      end
    end
  end

  // Watchdog: end the run if it hangs
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rotational_anisotropy_field_4_1_unit_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Axis-aligned spins, zero projections, k extremes and LSB, full-scale vectors
  // that saturate every result, and both values of the last flag.
  task automatic send_corner_atoms();
    item_t set [12];
    int i;
    set[0]  = atom(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    set[1]  = atom(16384, 0, 0, 16384, 0, 0, 0, 16384, 0, 32'sd65536, 1'b0);
    set[2]  = atom(0, 16384, 0, 16384, 0, 0, 0, 16384, 0, 32'sd65536, 1'b0);
    set[3]  = atom(11585, 11585, 0, 16384, 0, 0, 0, 16384, 0, -32'sd65536, 1'b1);
    set[4]  = atom(0, 0, 16384, 0, 0, 16384, 16384, 0, 0, 32'sh7fffffff, 1'b0);
    set[5]  = atom(0, 0, 16384, 0, 0, 16384, 16384, 0, 0, 32'sh80000000, 1'b0);
    set[6]  = atom(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                   32'sh7fffffff, 1'b1);
    set[7]  = atom(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768, 32'sh80000000, 1'b0);
    set[8]  = atom(32767, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 32767,
                   32'sh7fffffff, 1'b0);
    set[9]  = atom(9459, 9459, 9459, 0, 0, 16384, 16384, 0, 0, 32'sd1, 1'b0);
    set[10] = atom(9459, 9459, 9459, 0, 0, 16384, 16384, 0, 0, -32'sd1, 1'b1);
    set[11] = atom(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768,
                   32'sd65536, 1'b1);
    gap_pct   = 30;
    stall_pct = 30;
    for (i = 0; i < 12; i++) begin
      send_atom(set[i]);
      corner_atoms++;
    end
  endtask

  task automatic run_random_atoms(input int count);
    repeat (count) send_atom(random_atom());
  endtask

  // Enable is still at its reset value: field increments must read zero
  task automatic test_corners_at_reset();
    send_corner_atoms();
  endtask

  task automatic test_corners_enabled();
    write_enable(1'b1);
    send_corner_atoms();
  endtask

  task automatic test_random_enabled();
    write_enable(1'b1);
    gap_pct   = 25;
    stall_pct = 25;
    run_random_atoms(350);
  endtask

  task automatic test_random_disabled();
    write_enable(1'b0);
    gap_pct   = 25;
    stall_pct = 25;
    run_random_atoms(200);
  endtask

  // Full rate: no input gaps and no output stalls
  task automatic test_back_to_back();
    write_enable(1'b1);
    gap_pct   = 0;
    stall_pct = 0;
    run_random_atoms(200);
  endtask

  // Output stalls most of the time so the pipeline fills and stops
  task automatic test_heavy_backpressure();
    gap_pct   = 10;
    stall_pct = 60;
    run_random_atoms(150);
  endtask

  // Hold the sender until the pipeline is empty, then restart the stream
  task automatic test_drain_midstream();
    write_enable(1'b0);
    gap_pct   = 20;
    stall_pct = 20;
    run_random_atoms(75);
    drain_results();
    run_random_atoms(75);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.spin_x      = '0;
    in_ch.spin_y      = '0;
    in_ch.spin_z      = '0;
    in_ch.easy_axis_x = '0;
    in_ch.easy_axis_y = '0;
    in_ch.easy_axis_z = '0;
    in_ch.side_axis_x = '0;
    in_ch.side_axis_y = '0;
    in_ch.side_axis_z = '0;
    in_ch.aniso_const = '0;
    in_ch.last_atom   = 1'b0;
    out_ch.ready      = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.wdata      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_corners_at_reset();
    test_corners_enabled();
    test_random_enabled();
    test_random_disabled();
    test_back_to_back();
    test_heavy_backpressure();
    test_drain_midstream();

    // Let any stray result surface before the verdict
    drain_results();
    repeat (2 * NumStages) @(negedge clk);

    $display("Sent %0d atoms (%0d corner cases), checked %0d results.",
             atoms_sent, corner_atoms, results_seen);
    $display("Enable written %0d times; ran at full rate, with gaps and long stalls.",
             cfg_writes);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("rotational_anisotropy_field_4_1_unit_tb: PASS");
    end else begin
      $display("rotational_anisotropy_field_4_1_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
